>>> src/crt_pkg.sv
// Shared types, codes and sizing for the chunk reassembly table.
`default_nettype none
package crt_pkg;
	localparam int SLOTS_DEF   = 16;
	localparam int MAX_LEN_DEF = 512;
	localparam int SLOT_W_MAX  = 8;
	localparam int LEN_W_MAX   = 9;
	localparam int ROW_W_MAX   = 6;

	typedef enum logic [1:0] {
		CMD_FEED      = 2'd0,
		CMD_DROP_ONE  = 2'd1,
		CMD_DROP_LINK = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_ACC  = 2'd0,
		STAT_WORD = 2'd1,
		STAT_ERR  = 2'd2,
		STAT_DROP = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_READ,
		ST_OUTW,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_W_MAX-1:0] slot;
		logic [LEN_W_MAX-1:0]  len;
		logic [3:0]            cnt;
		logic [63:0]           data;
	} bs_wr_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_W_MAX-1:0] slot;
		logic [ROW_W_MAX-1:0]  row;
	} bs_rd_t;
endpackage
`default_nettype wire

>>> src/crt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module crt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> src/crt_byte_store.sv
// Byte store split into eight byte lanes, with rotated append writes.
`default_nettype none
module crt_byte_store
	import crt_pkg::*;
#(
	parameter int SLOTS   = SLOTS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire bs_wr_t      wr,
	input  wire bs_rd_t      rd,
	output logic      [63:0] rdata
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(MAX_LEN);
	localparam int RB = LW - 3;
	localparam int AW = SW + RB;
	localparam int DEPTH = 2 ** AW;

	logic [AW-1:0] raddr;
	assign raddr = {wr.en ? rd.slot[SW-1:0] : rd.slot[SW-1:0], rd.row[RB-1:0]};

	for (genvar l = 0; l < 8; l++) begin : g_lane
		logic [2:0]    off;
		logic          we;
		logic [LW-1:0] pos;
		logic [63:0]   shifted;
		logic [AW-1:0] waddr;

		assign off     = 3'(l) - wr.len[2:0];
		assign we      = wr.en && ({1'b0, off} < wr.cnt);
		assign pos     = wr.len[LW-1:0] + LW'(off);
		assign shifted = wr.data >> {off, 3'b000};
		assign waddr   = {wr.slot[SW-1:0], pos[LW-1:3]};

		crt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_lane (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (shifted[7:0]),
			.re    (rd.en),
			.raddr (raddr),
			.rdata (rdata[8*l +: 8])
		);
	end
endmodule
`default_nettype wire

>>> src/chunk_reassembly_table.sv
// Top level: slot table, scan and decision sequencer, result register.
// Usage:
//  Requests enter on s_*: tuser carries cmd, tlast carries fragment_end,
//  tdata the key, payload, byte count and more_follows. Results leave on m_*:
//  tuser is status, tlast marks the final result of a request.
//  Each request is handled alone; s_tready is high only while the sequencer
//  waits for work. A request first scans the slot table memory one entry a
//  cycle, set by the single read port of the slot table. Drop requests then
//  go to the result register; feed pieces pass a decision step first. Nop
//  commands and discarded pieces skip the scan and go straight to the result.
//  A completing piece, after the decision, emits its words one by one (byte
//  lane read, then output load, which waits for a free result register),
//  ceil(length / 8) words, at least one.
//  The result register lets a new request be taken while the last result
//  waits; when m_tready stays low the sequencer holds at its next result.
//  Reset clears the busy flags, the discard flag and the result valid flag;
//  there is no clearing pass, the memories hold no reset state.
`default_nettype none
module chunk_reassembly_table
	import crt_pkg::*;
#(
	parameter int SLOTS   = SLOTS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// link[7:0], transfer_tag[71:8], data_bytes[135:72], byte_count[139:136],
	// more_follows[140], zero[143:141]
	input  wire logic [143:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]   s_tuser,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// data_word[63:0], word_bytes[67:64], total_length[76:68], zero[79:77]
	output logic      [79:0]  m_tdata,
	// status[1:0]
	output logic      [1:0]   m_tuser,
	output logic              m_tlast
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(MAX_LEN);
	localparam int RB = LW - 3;
	localparam int TW = 72 + LW;
	localparam logic [SW:0] SLOTS_C = (SW + 1)'(SLOTS);
	localparam logic [LW:0] MAX_C   = (LW + 1)'(MAX_LEN);

	state_t st_q, st_d;

	cmd_t          cmd_q;
	logic [7:0]    link_q;
	logic [63:0]   tag_q;
	logic [63:0]   data_q;
	logic [3:0]    cnt_q;
	logic          fend_q, more_q;
	logic [SW:0]   idx_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;
	logic          found_q, free_ok_q;
	logic [SW-1:0] match_q, free_q, s_q;
	logic [LW-1:0] mlen_q, len_q;
	logic [RB-1:0] row_q;
	status_t       rstat_q;
	logic [8:0]    rtot_q;
	logic          discard_q;
	logic [SLOTS-1:0] busy_q;

	logic          out_v_q;
	status_t       out_stat_q;
	logic [63:0]   out_word_q;
	logic [3:0]    out_wb_q;
	logic [8:0]    out_tot_q;
	logic          out_last_q;

	logic [TW-1:0] tb_rdata;
	logic          tb_we;
	logic [63:0]   bs_rdata;
	bs_wr_t        bs_wr;
	bs_rd_t        bs_rd;

	logic          out_free, accept, hit, link_hit, e_busy, load_out;
	logic          have, over, ok;
	logic [SW-1:0] use_s;
	logic [LW-1:0] base, newlen, pos;
	logic [LW:0]   rem, pos_end;
	logic          w_last;
	logic [3:0]    wb;
	logic [63:0]   word_m;

	assign out_free = !out_v_q || m_tready;
	assign load_out = (st_q == ST_OUTW) || (st_q == ST_RESP);
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign e_busy   = busy_q[idx_s1];
	assign link_hit = vld_s1 && e_busy && (tb_rdata[7:0] == link_q);
	assign hit      = link_hit && (tb_rdata[71:8] == tag_q);

	assign use_s  = found_q ? match_q : free_q;
	assign base   = found_q ? mlen_q : '0;
	assign have   = found_q || free_ok_q;
	assign over   = ({1'b0, base} + (LW + 1)'(cnt_q) + (LW + 1)'(1)) > MAX_C;
	assign ok     = have && !over;
	assign newlen = base + LW'(cnt_q);

	assign pos     = LW'({row_q, 3'b000});
	assign rem     = {1'b0, len_q} - {1'b0, pos};
	assign pos_end = {1'b0, pos} + (LW + 1)'(8);
	assign w_last  = pos_end >= {1'b0, len_q};
	assign wb      = (rem >= (LW + 1)'(8)) ? 4'd8 : rem[3:0];
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			word_m[8*b +: 8] = (4'(b) < wb) ? bs_rdata[8*b +: 8] : 8'h00;
		end
	end

	assign tb_we = (st_q == ST_DECIDE) && (cmd_q == CMD_FEED) && ok;

	always_comb begin
		bs_wr      = '0;
		bs_wr.en   = tb_we;
		bs_wr.slot = SLOT_W_MAX'(use_s);
		bs_wr.len  = LEN_W_MAX'(base);
		bs_wr.cnt  = cnt_q;
		bs_wr.data = data_q;
		bs_rd      = '0;
		bs_rd.en   = (st_q == ST_READ);
		bs_rd.slot = SLOT_W_MAX'(s_q);
		bs_rd.row  = ROW_W_MAX'(row_q);
	end

	crt_ram #(.WIDTH(TW), .DEPTH(2 ** SW)) u_table (
		.clk   (clk),
		.we    (tb_we),
		.waddr (use_s),
		.wdata ({newlen, tag_q, link_q}),
		.re    (st_q == ST_SCAN),
		.raddr (idx_q[SW-1:0]),
		.rdata (tb_rdata)
	);

	crt_byte_store #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_bytes (
		.clk   (clk),
		.wr    (bs_wr),
		.rd    (bs_rd),
		.rdata (bs_rdata)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd_t'(s_tuser) == CMD_NOP
					    || (cmd_t'(s_tuser) == CMD_FEED && discard_q)) begin
						st_d = ST_RESP;
					end else begin
						st_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == SLOTS_C && !vld_s1) begin
					st_d = (cmd_q == CMD_FEED) ? ST_DECIDE : ST_RESP;
				end
			end
			ST_DECIDE: begin
				if (ok && fend_q && !more_q) begin
					st_d = ST_READ;
				end else begin
					st_d = ST_RESP;
				end
			end
			ST_READ: st_d = ST_OUTW;
			ST_OUTW: begin
				if (out_free) begin
					st_d = w_last ? ST_IDLE : ST_READ;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			discard_q <= 1'b0;
			vld_s1    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			vld_s1 <= (st_q == ST_SCAN) && (idx_q < SLOTS_C);
			if (out_free) begin
				out_v_q <= load_out;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept && cmd_t'(s_tuser) == CMD_FEED && discard_q && s_tlast) begin
						discard_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if ((cmd_q == CMD_DROP_ONE && hit)
					    || (cmd_q == CMD_DROP_LINK && link_hit)) begin
						busy_q[idx_s1] <= 1'b0;
					end
				end
				ST_DECIDE: begin
					if (!ok) begin
						if (have) begin
							busy_q[use_s] <= 1'b0;
						end
						if (!fend_q) begin
							discard_q <= 1'b1;
						end
					end else begin
						busy_q[use_s] <= 1'b1;
					end
				end
				ST_OUTW: begin
					if (out_free && w_last) begin
						busy_q[s_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q     <= cmd_t'(s_tuser);
				link_q    <= s_tdata[7:0];
				tag_q     <= s_tdata[71:8];
				data_q    <= s_tdata[135:72];
				cnt_q     <= (s_tdata[139:136] > 4'd8) ? 4'd8 : s_tdata[139:136];
				more_q    <= s_tdata[140];
				fend_q    <= s_tlast;
				idx_q     <= '0;
				found_q   <= 1'b0;
				free_ok_q <= 1'b0;
				rtot_q    <= '0;
				rstat_q   <= (cmd_t'(s_tuser) == CMD_DROP_ONE
				              || cmd_t'(s_tuser) == CMD_DROP_LINK) ? STAT_DROP : STAT_ACC;
			end
			ST_SCAN: begin
				if (idx_q < SLOTS_C) begin
					idx_q <= idx_q + (SW + 1)'(1);
				end
				idx_s1 <= idx_q[SW-1:0];
				if (hit && !found_q) begin
					found_q <= 1'b1;
					match_q <= idx_s1;
					mlen_q  <= tb_rdata[72 +: LW];
				end
				if (vld_s1 && !e_busy && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q    <= idx_s1;
				end
			end
			ST_DECIDE: begin
				s_q    <= use_s;
				len_q  <= newlen;
				row_q  <= '0;
				rstat_q <= ok ? STAT_ACC : STAT_ERR;
				rtot_q  <= ok ? 9'(newlen) : '0;
			end
			ST_OUTW: begin
				if (out_free) begin
					out_stat_q <= STAT_WORD;
					out_word_q <= word_m;
					out_wb_q   <= wb;
					out_tot_q  <= 9'(len_q);
					out_last_q <= w_last;
					row_q      <= row_q + RB'(1);
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_stat_q <= rstat_q;
					out_word_q <= '0;
					out_wb_q   <= '0;
					out_tot_q  <= rtot_q;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_tot_q, out_wb_q, out_word_q};

`ifndef SYNTHESIS
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DECIDE && ok) |-> ({1'b0, newlen} < MAX_C))
		else $error("stored length reaches limit");
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DECIDE) |-> !vld_s1)
		else $error("decision taken while scan pending");
	a_word_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUTW) |-> (wb <= 4'd8))
		else $error("word byte count out of range");
	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> busy_q[s_q])
		else $error("readout of a free slot");
`endif
endmodule
`default_nettype wire
